// ----- design/hcbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pkg: shared types and constants of the code bit packer
// Mode codes, field widths, default parameter values and the result word.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int MAX_CODE_LEN_DEF = 16;
	localparam int SYMBOL_COUNT_DEF = 256;

	localparam int CODE_W        = 16;
	localparam int LEN_W         = 5;
	localparam int BYTE_LAST_BIT = 7;
	localparam int FIFO_DEPTH    = 4;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_ENCODE = 2'd1;
	localparam logic [1:0] MODE_FLUSH  = 2'd2;

	typedef struct packed {
		logic [BYTE_LAST_BIT:0] data;
		logic [2:0]             pad;
		logic                   stream_end;
		logic                   last;
	} result_t;

	// up to two result words enter the output queue per cycle; b only with a
	typedef struct packed {
		logic    push_a;
		logic    push_b;
		result_t res_a;
		result_t res_b;
	} fifo_push_t;

endpackage

// ----- design/hcbp_out_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_out_fifo: result queue of the code bit packer
// Takes up to two words per cycle, hands out one word per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module hcbp_out_fifo import hcbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_push_t push,
	output logic       room2,
	output logic       out_valid,
	input  logic       out_stall,
	output result_t    head
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	result_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   n_push;
	logic               pop;

	assign pop       = out_valid && !out_stall;
	assign n_push    = CNT_W'(push.push_a) + CNT_W'(push.push_b);
	assign out_valid = (cnt_q != '0);
	assign room2     = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.push_a) begin
			mem_q[wr_q] <= push.res_a;
		end
		if (push.push_b) begin
			mem_q[wr_q + PTR_W'(1)] <= push.res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(n_push);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + n_push - CNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("output queue overfilled");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push_b |-> push.push_a)
		else $error("second word pushed without first");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.push_a |-> room2)
		else $error("word pushed without room for two");

endmodule

// ----- design/huffman_code_bit_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer: table-driven variable-length encoder, MSB-first
// Loads code table entries, packs symbol codes into bytes, flushes with pad.
// ----------------------------------------------------------------------------
// The block accepts one word per clock unless stalled. A word is registered
// with its code table read; the next stage merges the code into the bit
// accumulator and queues finished bytes, so a byte passes the stage register
// and then the output queue. The output side delivers one byte per cycle
// unless out_stall is high, from a four-word queue; a symbol that completes
// two bytes queues two words, and the input stalls only while the queue has
// fewer than two free slots. Loads take effect for any encode accepted after
// them. Table entries that were never loaded hold no defined code.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer import hcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             mode,
	input  logic [7:0]             symbol,
	input  logic [CODE_W-1:0]      code_bits,
	input  logic [LEN_W-1:0]       code_length,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [BYTE_LAST_BIT:0] out_byte,
	output logic [2:0]             pad_bits,
	output logic                   stream_end,
	output logic                   last_of_run
);

	localparam int ADDR_W    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int LEN_LIMIT = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
	localparam int ENTRY_W   = LEN_W + CODE_W;
	localparam int ACC_W     = BYTE_LAST_BIT + 1;
	localparam int V_W       = ACC_W + CODE_W;
	localparam int TOT_W     = $clog2(BYTE_LAST_BIT + CODE_W + 1);

	localparam logic [LEN_W-1:0] LEN_LIMIT_V = LEN_W'(LEN_LIMIT);

	logic                 in_accept;
	logic                 sym_ok;
	logic [LEN_W-1:0]     clen_sat;
	logic [CODE_W:0]      load_mask;
	logic [CODE_W-1:0]    code_masked;

	logic [ENTRY_W-1:0]   code_mem [SYMBOL_COUNT];

	logic                 valid_s1;
	logic [1:0]           mode_s1;
	logic                 sym_ok_s1;
	logic [ENTRY_W-1:0]   entry_s1;

	logic [ACC_W-1:0]     acc_q;
	logic [2:0]           pend_q;
	logic [ACC_W-1:0]     acc_next;
	logic [2:0]           pend_next;

	logic                 adv;
	logic                 room2;
	logic [LEN_W-1:0]     len;
	logic [CODE_W-1:0]    code;
	logic [V_W-1:0]       merged;
	logic [TOT_W-1:0]     total;
	logic [V_W-1:0]       shifted0;
	logic [V_W-1:0]       shifted1;
	logic [ACC_W-1:0]     rem_mask;
	logic [2:0]           flush_pad;
	logic [ACC_W-1:0]     flush_byte;
	fifo_push_t           push;
	result_t              head;

	assign in_stall  = valid_s1 && !adv;
	assign in_accept = in_valid && !in_stall;
	assign sym_ok    = (32'(symbol) < SYMBOL_COUNT);

	// saturate the length and drop code bits above it
	assign clen_sat    = (code_length > LEN_LIMIT_V) ? LEN_LIMIT_V : code_length;
	assign load_mask   = ((CODE_W + 1)'(1) << clen_sat) - (CODE_W + 1)'(1);
	assign code_masked = code_bits & load_mask[CODE_W-1:0];

	always_ff @(posedge clk) begin
		if (in_accept && (mode == MODE_LOAD) && sym_ok) begin
			code_mem[symbol[ADDR_W-1:0]] <= {clen_sat, code_masked};
		end
		if (in_accept) begin
			entry_s1 <= code_mem[symbol[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1   <= mode;
			sym_ok_s1 <= sym_ok;
		end
	end

	// merge stage: advance only with room for the worst case of two bytes
	assign adv = valid_s1 && room2;

	assign len      = entry_s1[ENTRY_W-1:CODE_W];
	assign code     = entry_s1[CODE_W-1:0];
	assign merged   = (V_W'(acc_q) << len) | V_W'(code);
	assign total    = TOT_W'(pend_q) + TOT_W'(len);
	assign shifted0 = merged >> (total - TOT_W'(ACC_W));
	assign shifted1 = merged >> (total - TOT_W'(2 * ACC_W));
	assign rem_mask = (ACC_W'(1) << total[2:0]) - ACC_W'(1);

	assign flush_pad  = 3'd0 - pend_q;
	assign flush_byte = acc_q << flush_pad;

	always_comb begin
		push      = '0;
		acc_next  = acc_q;
		pend_next = pend_q;
		if (adv) begin
			unique case (mode_s1)
				MODE_ENCODE: begin
					if (sym_ok_s1) begin
						acc_next  = merged[ACC_W-1:0] & rem_mask;
						pend_next = total[2:0];
						if (total >= TOT_W'(2 * ACC_W)) begin
							push.push_a = 1'b1;
							push.push_b = 1'b1;
							push.res_a  = '{data: shifted0[ACC_W-1:0], pad: 3'd0,
								stream_end: 1'b0, last: 1'b0};
							push.res_b  = '{data: shifted1[ACC_W-1:0], pad: 3'd0,
								stream_end: 1'b0, last: 1'b1};
						end else if (total >= TOT_W'(ACC_W)) begin
							push.push_a = 1'b1;
							push.res_a  = '{data: shifted0[ACC_W-1:0], pad: 3'd0,
								stream_end: 1'b0, last: 1'b1};
						end
					end
				end
				MODE_FLUSH: begin
					acc_next    = '0;
					pend_next   = '0;
					push.push_a = 1'b1;
					push.res_a  = '{data: flush_byte, pad: flush_pad,
						stream_end: 1'b1, last: 1'b1};
				end
				default: begin
					// loads and the unused mode leave the accumulator alone
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= '0;
		end else begin
			acc_q  <= acc_next;
			pend_q <= pend_next;
		end
	end

	hcbp_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room2     (room2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign out_byte    = head.data;
	assign pad_bits    = head.pad;
	assign stream_end  = head.stream_end;
	assign last_of_run = head.last;

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q >> pend_q) == '0)
		else $error("accumulator holds bits above pending count");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (mode_s1 == MODE_FLUSH)) |=> ((pend_q == '0) && (acc_q == '0)))
		else $error("flush left pending bits");

endmodule
